// ===== rtl/core/battery_voltage_to_charge_level_macros.svh =====
// assertion helpers for the checker file
`ifndef BATTERY_VOLTAGE_TO_CHARGE_LEVEL_MACROS_SVH
`define BATTERY_VOLTAGE_TO_CHARGE_LEVEL_MACROS_SVH

// property checked on every clock edge outside reset
`define BVCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define BVCL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bvcl_pkg.sv =====
package bvcl_pkg;

  // field widths
  localparam int ADC_BITS     = 12;
  localparam int VOLT_W       = 16;
  localparam int PCT_W        = 7;
  localparam int CLASS_W      = 2;
  localparam int OFFSET_W     = 12;
  localparam int THRESH_W     = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd1;

  // register reset values
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd1600;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd60;

  // code * 3000 / 4095 == code * 200 / 273, done as one reciprocal multiply
  // (exact for every 12-bit code)
  localparam int MUL_W       = 28;
  localparam int PROD_W      = ADC_BITS + MUL_W;
  localparam int MV_W        = 12;
  localparam logic [MUL_W-1:0] SCALE_MUL = 28'd196656200;
  localparam int SCALE_SHIFT = 28;

  // mv * 163 / 13, again one reciprocal multiply, exact for mv up to 3000
  localparam logic [MUL_W-1:0] DIV_MUL = 28'd210360628;
  localparam int DIV_SHIFT   = 24;

  // voltage / percent table, descending
  localparam int TABLE_POINTS = 10;
  localparam logic [VOLT_W-1:0] VOLT_PTS [TABLE_POINTS] = '{
    16'd37650, 16'd37600, 16'd37500, 16'd37120, 16'd36720,
    16'd36310, 16'd35870, 16'd35440, 16'd34900, 16'd34500
  };
  localparam logic [PCT_W-1:0] PCT_PTS [TABLE_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10
  };

  // per-segment slope, 100 * dp / dv truncated
  localparam int SLOPE_W = 5;
  localparam logic [SLOPE_W-1:0] SLOPES [TABLE_POINTS-1] = '{
    SLOPE_W'(100 * (PCT_PTS[0] - PCT_PTS[1]) / (VOLT_PTS[0] - VOLT_PTS[1])),
    SLOPE_W'(100 * (PCT_PTS[1] - PCT_PTS[2]) / (VOLT_PTS[1] - VOLT_PTS[2])),
    SLOPE_W'(100 * (PCT_PTS[2] - PCT_PTS[3]) / (VOLT_PTS[2] - VOLT_PTS[3])),
    SLOPE_W'(100 * (PCT_PTS[3] - PCT_PTS[4]) / (VOLT_PTS[3] - VOLT_PTS[4])),
    SLOPE_W'(100 * (PCT_PTS[4] - PCT_PTS[5]) / (VOLT_PTS[4] - VOLT_PTS[5])),
    SLOPE_W'(100 * (PCT_PTS[5] - PCT_PTS[6]) / (VOLT_PTS[5] - VOLT_PTS[6])),
    SLOPE_W'(100 * (PCT_PTS[6] - PCT_PTS[7]) / (VOLT_PTS[6] - VOLT_PTS[7])),
    SLOPE_W'(100 * (PCT_PTS[7] - PCT_PTS[8]) / (VOLT_PTS[7] - VOLT_PTS[8])),
    SLOPE_W'(100 * (PCT_PTS[8] - PCT_PTS[9]) / (VOLT_PTS[8] - VOLT_PTS[9]))
  };

  // offset into a segment is below the widest segment span (540)
  localparam int DV_W    = 10;
  localparam int PROD3_W = SLOPE_W + DV_W;

  // x / 100 as x * 20972 >> 21, exact for x below 43690
  localparam int PDIV_W  = 15;
  localparam logic [PDIV_W-1:0] PCT_DIV_MUL = 15'd20972;
  localparam int PCT_DIV_SHIFT = 21;
  localparam int PROD4_W = PROD3_W + PDIV_W;

  // out-of-table percentages
  localparam logic [PCT_W-1:0] PCT_BELOW = 7'd10;
  localparam logic [PCT_W-1:0] PCT_ABOVE = 7'd99;

  // class bounds
  localparam logic [PCT_W-1:0] CHARGED_LO = 7'd70;
  localparam logic [PCT_W-1:0] CHARGED_HI = 7'd100;
  localparam logic [PCT_W-1:0] MEDIUM_LO  = 7'd30;

  // class codes
  localparam logic [CLASS_W-1:0] CLASS_CHARGED    = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MEDIUM     = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_DISCHARGED = 2'd2;

  // scaled voltage beat between the scaler and the interpolator
  typedef struct packed {
    logic              valid;
    logic [VOLT_W-1:0] voltage;
  } volt_beat_t;

endpackage

// ===== rtl/core/bvcl_scale.sv =====
module bvcl_scale import bvcl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [ADC_BITS-1:0] in_code,
  input  logic [OFFSET_W-1:0] offset,
  output volt_beat_t          out_beat
);

  logic              s1_valid;
  logic [PROD_W-1:0] s1_prod;
  logic              s2_valid;
  logic [PROD_W-1:0] s2_prod;
  logic              s3_valid;
  logic [VOLT_W-1:0] s3_voltage;

  logic [MV_W-1:0]   div_mv;
  logic [VOLT_W:0]   volt_sum;

  // divider millivolts from the first product, battery voltage from the second
  assign div_mv   = s1_prod[SCALE_SHIFT +: MV_W];
  assign volt_sum = {1'b0, s2_prod[DIV_SHIFT +: VOLT_W]} + (VOLT_W + 1)'(offset);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1_prod    <= PROD_W'(in_code) * PROD_W'(SCALE_MUL);
    s2_prod    <= PROD_W'(div_mv) * PROD_W'(DIV_MUL);
    s3_voltage <= volt_sum[VOLT_W-1:0];
  end

  assign out_beat.valid   = s3_valid;
  assign out_beat.voltage = s3_voltage;

endmodule

// ===== rtl/core/bvcl_interp.sv =====
module bvcl_interp import bvcl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  volt_beat_t          in_beat,
  input  logic [THRESH_W-1:0] low_threshold,
  output logic                done,
  output logic [VOLT_W-1:0]   battery_voltage,
  output logic [PCT_W-1:0]    charge_percent,
  output logic [CLASS_W-1:0]  charge_class,
  output logic                low_indicator
);

  // stage a: table compares
  logic                    a_valid;
  logic [VOLT_W-1:0]       a_volt;
  logic [TABLE_POINTS-1:0] a_ge;
  // stage b: slope times offset into segment
  logic                    b_valid;
  logic [VOLT_W-1:0]       b_volt;
  logic [PROD3_W-1:0]      b_prod;
  logic [PCT_W-1:0]        b_base;
  logic                    b_below;
  logic                    b_above;
  // stage c: divide by 100 product
  logic                    c_valid;
  logic [VOLT_W-1:0]       c_volt;
  logic [PROD4_W-1:0]      c_prod;
  logic [PCT_W-1:0]        c_base;
  logic                    c_below;
  logic                    c_above;

  logic [VOLT_W-1:0]       seg_lo;
  logic [SLOPE_W-1:0]      seg_slope;
  logic [PCT_W-1:0]        seg_base;
  logic [VOLT_W-1:0]       seg_diff;
  logic [PCT_W-1:0]        pct_next;
  logic [CLASS_W-1:0]      class_next;

  // segment select: the table is descending, so the compare bits are a thermometer
  always_comb begin
    seg_lo    = '0;
    seg_slope = '0;
    seg_base  = '0;
    for (int i = 0; i < TABLE_POINTS - 1; i++) begin
      if (a_ge[i+1] && !a_ge[i]) begin
        seg_lo    = VOLT_PTS[i+1];
        seg_slope = SLOPES[i];
        seg_base  = PCT_PTS[i+1];
      end
    end
  end

  assign seg_diff = a_volt - seg_lo;

  // final percentage and its class
  always_comb begin
    if (c_below) begin
      pct_next = PCT_BELOW;
    end else if (c_above) begin
      pct_next = PCT_ABOVE;
    end else begin
      pct_next = c_base + c_prod[PCT_DIV_SHIFT +: PCT_W];
    end
    if (pct_next >= CHARGED_LO && pct_next <= CHARGED_HI) begin
      class_next = CLASS_CHARGED;
    end else if (pct_next >= MEDIUM_LO) begin
      class_next = CLASS_MEDIUM;
    end else begin
      class_next = CLASS_DISCHARGED;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= in_beat.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      done    <= c_valid;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    a_volt <= in_beat.voltage;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      a_ge[i] <= in_beat.voltage >= VOLT_PTS[i];
    end

    b_volt  <= a_volt;
    b_prod  <= PROD3_W'(seg_slope) * PROD3_W'(seg_diff[DV_W-1:0]);
    b_base  <= seg_base;
    b_below <= !a_ge[TABLE_POINTS-1];
    b_above <= a_ge[0];

    c_volt  <= b_volt;
    c_prod  <= PROD4_W'(b_prod) * PROD4_W'(PCT_DIV_MUL);
    c_base  <= b_base;
    c_below <= b_below;
    c_above <= b_above;

    battery_voltage <= c_volt;
    charge_percent  <= pct_next;
    charge_class    <= class_next;
    low_indicator   <= pct_next < low_threshold;
  end

endmodule

// ===== rtl/core/battery_voltage_to_charge_level.sv =====
// Battery voltage to charge level. Each beat taken on start (busy is never
// raised) is one filtered 12-bit ADC code; it is scaled to battery voltage,
// offset, and interpolated over a ten-point table into a 10..99 percent
// charge, a charge class and a low flag. The pipeline takes one sample every
// cycle and returns each result with a one-cycle done pulse; done cannot be
// held off, so the receiver must capture the result in that cycle. Each
// sample passes through these registered stages in order: two reciprocal
// multiplies for the scaling, the offset add, the table compare, the slope
// multiply, the divide-by-100 multiply and the output register. Register
// writes are always accepted (cfg_ready is tied high) and must only be made
// while no sample is in flight.
module battery_voltage_to_charge_level import bvcl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ADC_BITS-1:0]   filtered_adc,
  output logic                  done,
  output logic [VOLT_W-1:0]     battery_voltage,
  output logic [PCT_W-1:0]      charge_percent,
  output logic [CLASS_W-1:0]    charge_class,
  output logic                  low_indicator,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [OFFSET_W-1:0] voltage_offset;
  logic [THRESH_W-1:0] low_threshold;
  volt_beat_t          volt_beat;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_offset <= OFFSET_RESET;
      low_threshold  <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VOLTAGE_OFFSET: voltage_offset <= cfg_data[OFFSET_W-1:0];
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // adc code to battery voltage
  bvcl_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .in_code  (filtered_adc),
    .offset   (voltage_offset),
    .out_beat (volt_beat)
  );

  // battery voltage to percent, class and low flag
  bvcl_interp u_interp (
    .clk             (clk),
    .rst             (rst),
    .in_beat         (volt_beat),
    .low_threshold   (low_threshold),
    .done            (done),
    .battery_voltage (battery_voltage),
    .charge_percent  (charge_percent),
    .charge_class    (charge_class),
    .low_indicator   (low_indicator)
  );

endmodule

// ===== rtl/core/bvcl_checker.sv =====
`include "battery_voltage_to_charge_level_macros.svh"

module bvcl_checker import bvcl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [PCT_W-1:0]   charge_percent,
  input logic [CLASS_W-1:0] charge_class
);

  // no result right after reset
  `BVCL_ASSERT_ALWAYS(a_quiet_after_reset, rst |=> !done, "done after reset")

  // every accepted beat yields a result
  `BVCL_ASSERT(a_latency, (start && !busy) |-> ##7 done, "result missing")

  // no result without an earlier accepted beat
  `BVCL_ASSERT(a_no_spurious, done |-> $past(start && !busy, 7), "spurious result")

  // percentage stays in range and the class agrees with it
  `BVCL_ASSERT(a_class_match,
    done |-> (charge_percent >= PCT_BELOW && charge_percent <= PCT_ABOVE &&
      ((charge_class == CLASS_CHARGED) == (charge_percent >= CHARGED_LO)) &&
      ((charge_class == CLASS_DISCHARGED) == (charge_percent < MEDIUM_LO))),
    "class or percent wrong")

endmodule

bind battery_voltage_to_charge_level bvcl_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .charge_percent (charge_percent),
  .charge_class   (charge_class)
);

// ===== tb/tb_top.sv =====
module tb_top;
  import bvcl_pkg::*;

  // spare register indexes, writes there must leave both registers alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // discharge curve, highest voltage first
  localparam int unsigned CURVE_MV [10] = '{
    37650, 37600, 37500, 37120, 36720, 36310, 35870, 35440, 34900, 34500
  };
  localparam int unsigned CURVE_PCT [10] = '{
    100, 90, 80, 70, 60, 50, 40, 30, 20, 10
  };

  localparam int RANDOM_PHASES    = 12;
  localparam int ITEMS_PER_PHASE  = 160;
  localparam int SETTLE_CYCLES    = 20;

  typedef struct packed {
    logic [VOLT_W-1:0]  volt;
    logic [PCT_W-1:0]   pct;
    logic [CLASS_W-1:0] cls;
    logic               low;
  } charge_reading_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [THRESH_W-1:0] thresh;
    logic [ADC_BITS-1:0] code;
    logic                typed;
    charge_reading_t     want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam charge_reading_t NO_WANT = '0;

  // directed samples; expected reading typed in only where obvious
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset settings: empty and full scale, then mid table and bit patterns
    '{12'd1600, 7'd60,  12'd0,    1'b1, '{16'd1600,  7'd10, CLASS_DISCHARGED, 1'b1}},
    '{12'd1600, 7'd60,  12'd4095, 1'b1, '{16'd39215, 7'd99, CLASS_CHARGED,    1'b0}},
    '{12'd1600, 7'd60,  12'd3700, 1'b0, NO_WANT},
    '{12'd1600, 7'd60,  12'd3800, 1'b0, NO_WANT},
    '{12'd1600, 7'd60,  12'hAAA,  1'b0, NO_WANT},
    '{12'd1600, 7'd60,  12'h555,  1'b0, NO_WANT},
    '{12'd1600, 7'd60,  12'd1,    1'b0, NO_WANT},
    '{12'd1600, 7'd60,  12'd3650, 1'b0, NO_WANT},
    // exactly on the top point, on the second point, just under the top
    '{12'd35,   7'd60,  12'd4095, 1'b1, '{16'd37650, 7'd99, CLASS_CHARGED,    1'b0}},
    '{12'd35,   7'd60,  12'd4090, 1'b0, NO_WANT},
    '{12'd34,   7'd60,  12'd4095, 1'b0, NO_WANT},
    // exactly on the lowest point, then one below it
    '{12'd521,  7'd100, 12'd3700, 1'b0, NO_WANT},
    '{12'd520,  7'd0,   12'd3700, 1'b1, '{16'd34499, 7'd10, CLASS_DISCHARGED, 1'b0}},
    '{12'd520,  7'd0,   12'd0,    1'b1, '{16'd520,   7'd10, CLASS_DISCHARGED, 1'b0}},
    // largest offset with a threshold above every percentage
    '{12'd4095, 7'd127, 12'd4095, 1'b1, '{16'd41710, 7'd99, CLASS_CHARGED,    1'b1}},
    '{12'd4095, 7'd127, 12'd0,    1'b1, '{16'd4095,  7'd10, CLASS_DISCHARGED, 1'b1}},
    // zero offset
    '{12'd0,    7'd11,  12'd0,    1'b1, '{16'd0,     7'd10, CLASS_DISCHARGED, 1'b1}},
    '{12'd0,    7'd11,  12'd4095, 1'b0, NO_WANT},
    '{12'd0,    7'd11,  12'd4094, 1'b0, NO_WANT},
    // percentage exactly on the class bounds, threshold equal to it, then a voltage one under the 30 percent point
    '{12'd1461, 7'd30,  12'd3700, 1'b0, NO_WANT},
    '{12'd3141, 7'd70,  12'd3700, 1'b0, NO_WANT},
    '{12'd1460, 7'd31,  12'd3700, 1'b0, NO_WANT}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ADC_BITS-1:0]   filtered_adc = '0;
  logic                  done;
  logic [VOLT_W-1:0]     battery_voltage;
  logic [PCT_W-1:0]      charge_percent;
  logic [CLASS_W-1:0]    charge_class;
  logic                  low_indicator;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies as the block should hold them
  logic [OFFSET_W-1:0] cur_offset = OFFSET_RESET;
  logic [THRESH_W-1:0] cur_thresh = THRESH_RESET;

  charge_reading_t readings_due [$];
  int              mismatches = 0;
  bit              steady = 1'b0;

  battery_voltage_to_charge_level uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .filtered_adc    (filtered_adc),
    .done            (done),
    .battery_voltage (battery_voltage),
    .charge_percent  (charge_percent),
    .charge_class    (charge_class),
    .low_indicator   (low_indicator),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // scale, offset and interpolate one adc code
  function automatic charge_reading_t predict_charge(logic [ADC_BITS-1:0] code,
                                                     logic [OFFSET_W-1:0] offs,
                                                     logic [THRESH_W-1:0] thresh);
    charge_reading_t r;
    int unsigned     c;
    int unsigned     mv;
    int unsigned     v;
    int unsigned     pct;
    int unsigned     slope;
    c   = code;
    mv  = (32'd3000 * c) / 32'd4095;
    v   = (mv * 32'd163) / 32'd13 + 32'(offs);
    pct = 99;
    if (v < CURVE_MV[9]) begin
      pct = 10;
    end else begin
      for (int i = 8; i >= 0; i--) begin
        if (v < CURVE_MV[i] && v >= CURVE_MV[i+1]) begin
          slope = (100 * (CURVE_PCT[i] - CURVE_PCT[i+1])) / (CURVE_MV[i] - CURVE_MV[i+1]);
          pct   = CURVE_PCT[i+1] + (slope * (v - CURVE_MV[i+1])) / 100;
        end
      end
    end
    r.volt = v[VOLT_W-1:0];
    r.pct  = pct[PCT_W-1:0];
    if (pct >= 70 && pct <= 100) begin
      r.cls = CLASS_CHARGED;
    end else if (pct >= 30) begin
      r.cls = CLASS_MEDIUM;
    end else begin
      r.cls = CLASS_DISCHARGED;
    end
    r.low = (pct < 32'(thresh));
    return r;
  endfunction

  // one register write beat
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_VOLTAGE_OFFSET: cur_offset = data[OFFSET_W-1:0];
      REG_LOW_THRESHOLD:  cur_thresh = data[THRESH_W-1:0];
      default: ;
    endcase
  endtask

  // drain the pipeline, write junk to a spare index, then load new settings
  task automatic apply_settings(logic [OFFSET_W-1:0] offs, logic [THRESH_W-1:0] thresh);
    logic [CFG_DATA_W-1:0] junk;
    @(negedge clk);
    start <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    junk = CFG_DATA_W'($urandom);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, junk);
    write_reg(REG_VOLTAGE_OFFSET, offs);
    // upper data bits are random and must be dropped by the block
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_LOW_THRESHOLD, {junk[CFG_DATA_W-1:THRESH_W], thresh});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // present one sample beat, with a random gap (none when steady) in front
  task automatic send_sample(logic [ADC_BITS-1:0] code, logic typed, charge_reading_t want);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    filtered_adc <= code;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    readings_due.push_back(typed ? want : predict_charge(code, cur_offset, cur_thresh));
  endtask

  // compare each done beat against the oldest expected reading
  always @(posedge clk) begin
    if (!rst && done) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected reading volt=%0d pct=%0d class=%0d low=%0b", $time,
                 battery_voltage, charge_percent, charge_class, low_indicator);
        mismatches++;
      end else begin
        charge_reading_t w;
        w = readings_due.pop_front();
        if (battery_voltage !== w.volt) begin
          $display("%0t: battery_voltage expected %0d got %0d", $time, w.volt, battery_voltage);
          mismatches++;
        end
        if (charge_percent !== w.pct) begin
          $display("%0t: charge_percent expected %0d got %0d", $time, w.pct, charge_percent);
          mismatches++;
        end
        if (charge_class !== w.cls) begin
          $display("%0t: charge_class expected %0d got %0d", $time, w.cls, charge_class);
          mismatches++;
        end
        if (low_indicator !== w.low) begin
          $display("%0t: low_indicator expected %0b got %0b", $time, w.low, low_indicator);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [OFFSET_W-1:0] offs;
    logic [THRESH_W-1:0] thresh;
    logic [ADC_BITS-1:0] code;
    longint              target;
    longint              scaled;
    longint              guess;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed rows, first ones under reset settings
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].offset != cur_offset || DIRECTED[r].thresh != cur_thresh)
        apply_settings(DIRECTED[r].offset, DIRECTED[r].thresh);
      send_sample(DIRECTED[r].code, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // random phases, each with its own settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin offs = '0;  thresh = 7'd100; end
        1: begin offs = '1;  thresh = 7'd0;   end
        2: begin offs = '1;  thresh = 7'd127; end
        default: begin
          offs = OFFSET_W'($urandom_range(0, 4095));
          if (p % 4 == 3) thresh = THRESH_W'($urandom_range(101, 127));
          else thresh = THRESH_W'($urandom_range(0, 100));
        end
      endcase
      apply_settings(offs, thresh);
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          // aim at a voltage around the curve under the current offset
          target = $urandom_range(34300, 37800);
          scaled = (target > cur_offset) ? target - cur_offset : 0;
          guess  = (scaled * 13 * 4095) / (163 * 3000) + longint'($urandom_range(0, 6)) - 3;
          if (guess < 0) guess = 0;
          if (guess > 4095) guess = 4095;
          code = guess[ADC_BITS-1:0];
        end else begin
          code = ADC_BITS'($urandom_range(0, 4095));
        end
        send_sample(code, 1'b0, NO_WANT);
      end
    end

    // wait for the last readings, then a quiet stretch
    @(negedge clk);
    start <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
